// ===== hdl/b64d_pkg.sv =====
// ---------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the alphabet lookup for the Base64 decoder.
// ---------------------------------------------------------------------------
package b64d_pkg;

	localparam int QDepth    = 16;
	localparam int QAw       = $clog2(QDepth);
	// worst case: item in the input stage and a new one each add three results
	localparam int QReadyMax = QDepth - 6;

	localparam logic [7:0] PadChar   = 8'h3D;
	localparam logic [6:0] SextetBad = 7'd64;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_CHR = 2'd1,
		ST_BAD_LEN = 2'd2,
		ST_BAD_PAD = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       final_flag;
		status_t    status;
	} result_t;

	// sextet value 0..63, or SextetBad outside the alphabet
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] v;
		v = SextetBad;
		if (c >= 8'h41 && c <= 8'h5A) begin
			v = 7'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			v = 7'(c - 8'h61) + 7'd26;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = 7'(c - 8'h30) + 7'd52;
		end else if (c == 8'h2B) begin
			v = 7'd62;
		end else if (c == 8'h2F) begin
			v = 7'd63;
		end
		return v;
	endfunction

endpackage

// ===== hdl/base64_decoder_checked_top.sv =====
// ---------------------------------------------------------------------------
// base64_decoder_checked_top
// Base64 decoder with message status, one character per request.
// ---------------------------------------------------------------------------
// Takes one character per cycle while s_axis_tready is high. Each request
// is registered, decoded in one pass against the group state, and its zero
// to three results go into a 16-entry result queue that drains one result
// per cycle on the master side while m_axis_tready is high. The input side
// holds tready low while the queue holds more than ten results, so with a
// stalled output it backs up; with a free-running output the sustained rate
// is one character per cycle. The last result of a message has tlast high and
// carries the status; on a nonzero status the consumer drops the earlier bytes.
// ---------------------------------------------------------------------------
module base64_decoder_checked_top
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_code
	input  logic       s_axis_tlast,   // end_mark
	input  logic       s_axis_tuser,   // [0] no_char
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] data_byte
	output logic       m_axis_tlast,   // final_flag
	output logic [2:0] m_axis_tuser    // [0] byte_valid, [2:1] status
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        end_s1;
	logic        none_s1;

	logic [1:0]  qpos_q, qpos_d;
	logic [17:0] acc_q, acc_d;
	status_t     err_q, err_d;
	logic [1:0]  pad_q, pad_d;

	result_t     res [3];
	logic [1:0]  nres;

	result_t     queue_q [QDepth];
	logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAw:0]   count_q;
	logic           pop;

	assign s_axis_tready = (count_q <= (QAw+1)'(QReadyMax));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_axis_tvalid && s_axis_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
			none_s1 <= s_axis_tuser;
		end
	end

	// decode one character against the group state
	always_comb begin
		logic [6:0]  v;
		logic [23:0] x;
		logic [1:0]  nb;
		logic        done;
		status_t     st;
		qpos_d = qpos_q;
		acc_d  = acc_q;
		err_d  = err_q;
		pad_d  = pad_q;
		nres   = 2'd0;
		x      = 24'd0;
		nb     = 2'd0;
		done   = 1'b0;
		st     = ST_OK;
		v      = sextet_of(char_s1);
		for (int k = 0; k < 3; k++) begin
			res[k] = '{data_byte: 8'd0, byte_valid: 1'b0, final_flag: 1'b0, status: ST_OK};
		end
		if (!none_s1 && err_q == ST_OK) begin
			if (pad_q != 2'd0 && qpos_q == 2'd0) begin
				err_d = ST_BAD_PAD;
			end else if (char_s1 == PadChar) begin
				if (qpos_q < 2'd2) begin
					err_d = ST_BAD_PAD;
				end else if (qpos_q == 2'd2) begin
					pad_d  = 2'd1;
					acc_d  = {acc_q[11:0], 6'd0};
					qpos_d = 2'd3;
				end else begin
					pad_d = pad_q + 2'd1;
					x     = {acc_q, 6'd0};
					nb    = (pad_d == 2'd2) ? 2'd1 : 2'd2;
					done  = 1'b1;
				end
			end else if (v == SextetBad) begin
				err_d = ST_BAD_CHR;
			end else if (pad_q != 2'd0) begin
				err_d = ST_BAD_PAD;
			end else if (qpos_q < 2'd3) begin
				acc_d  = {acc_q[11:0], v[5:0]};
				qpos_d = qpos_q + 2'd1;
			end else begin
				x    = {acc_q, v[5:0]};
				nb   = 2'd3;
				done = 1'b1;
			end
		end
		if (done) begin
			qpos_d = 2'd0;
			acc_d  = 18'd0;
			nres   = nb;
			res[0].data_byte  = x[23:16];
			res[0].byte_valid = 1'b1;
			res[1].data_byte  = x[15:8];
			res[1].byte_valid = (nb >= 2'd2);
			res[2].data_byte  = x[7:0];
			res[2].byte_valid = (nb == 2'd3);
			if (nb < 2'd2) begin
				res[1].data_byte = 8'd0;
			end
			if (nb < 2'd3) begin
				res[2].data_byte = 8'd0;
			end
		end
		if (end_s1) begin
			st = err_d;
			if (st == ST_OK && qpos_d != 2'd0) begin
				st = ST_BAD_LEN;
			end
			if (nres == 2'd0) begin
				nres = 2'd1;
			end
			res[nres-2'd1].final_flag = 1'b1;
			res[nres-2'd1].status     = st;
			qpos_d = 2'd0;
			acc_d  = 18'd0;
			err_d  = ST_OK;
			pad_d  = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qpos_q <= 2'd0;
			acc_q  <= 18'd0;
			err_q  <= ST_OK;
			pad_q  <= 2'd0;
		end else if (valid_s1) begin
			qpos_q <= qpos_d;
			acc_q  <= acc_d;
			err_q  <= err_d;
			pad_q  <= pad_d;
		end
	end

	// result queue
	assign pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < nres) begin
					queue_q[wr_ptr_q + QAw'(k)] <= res[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= wr_ptr_q + QAw'(nres);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAw'(1);
			end
			count_q <= count_q + (valid_s1 ? (QAw+1)'(nres) : '0)
				- (pop ? (QAw+1)'(1) : '0);
		end
	end

	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = queue_q[rd_ptr_q].data_byte;
	assign m_axis_tlast  = queue_q[rd_ptr_q].final_flag;
	assign m_axis_tuser  = {queue_q[rd_ptr_q].status, queue_q[rd_ptr_q].byte_valid};

endmodule
